FILE: rtl/tts_pkg.sv
// Shared constants and types for the tick task scheduler and watchdog.
// No dependencies; every other source file depends on this package.
`default_nettype none

package tts_pkg;

    localparam int TASK_SLOTS_DEF = 8;
    localparam int MASK_W         = 8;
    localparam int TIME_W         = 64;
    localparam int PERIOD_W       = 32;
    localparam int STEP_W         = 10;
    localparam int BOUND_W        = 32;
    localparam int OP_W           = 3;
    localparam int IDX_W          = 3;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;

    localparam logic [OP_W-1:0] OP_TICK        = 3'd0;
    localparam logic [OP_W-1:0] OP_SCAN        = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_TASK    = 3'd2;
    localparam logic [OP_W-1:0] OP_ARM_DELAYED = 3'd3;
    localparam logic [OP_W-1:0] OP_KICK        = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG_BOUND  = 2'd2;

    localparam logic [STEP_W-1:0] TIME_STEP_RST = 10'd1;

    // command from the top level to the slot table for the word in flight
    typedef struct packed {
        logic                go;
        logic                scan;
        logic                set;
        logic [IDX_W-1:0]    index;
        logic [PERIOD_W-1:0] period;
        logic [MASK_W-1:0]   done;
        logic [TIME_W-1:0]   now;
    } slot_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/tts_in_if.sv
// Input channel of the scheduler: valid/ready handshake and one item.
// Depends on tts_pkg for field widths.
`default_nettype none

interface tts_in_if;
    logic                              valid;
    logic                              ready;
    logic [tts_pkg::OP_W-1:0]          opcode;
    logic [tts_pkg::IDX_W-1:0]         slot_index;
    logic [tts_pkg::PERIOD_W-1:0]      slot_period;
    logic [tts_pkg::MASK_W-1:0]        done_mask;
    logic                              handler_ok;
    logic [tts_pkg::PERIOD_W-1:0]      delay_length;

    modport source (output valid, opcode, slot_index, slot_period, done_mask,
                    handler_ok, delay_length, input ready);
    modport sink   (input valid, opcode, slot_index, slot_period, done_mask,
                    handler_ok, delay_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/tts_out_if.sv
// Result channel of the scheduler: valid/ready handshake and one result.
// Depends on tts_pkg for field widths.
`default_nettype none

interface tts_out_if;
    logic                          valid;
    logic                          ready;
    logic [tts_pkg::MASK_W-1:0]    due_mask;
    logic                          delayed_fired;
    logic                          watchdog_expired;
    logic                          timeout_seen;
    logic [tts_pkg::TIME_W-1:0]    current_time;

    modport source (output valid, due_mask, delayed_fired, watchdog_expired,
                    timeout_seen, current_time, input ready);
    modport sink   (input valid, due_mask, delayed_fired, watchdog_expired,
                    timeout_seen, current_time, output ready);
endinterface

`default_nettype wire

FILE: rtl/tts_slots.sv
// Periodic task slot table: valid bits, periods, marks and the due compares.
// Depends on tts_pkg for slot_cmd_t and widths.
`default_nettype none

module tts_slots #(
    parameter int TASK_SLOTS = tts_pkg::TASK_SLOTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tts_pkg::slot_cmd_t         cmd,
    output logic [tts_pkg::MASK_W-1:0] due_mask
);
    import tts_pkg::*;

    logic [TASK_SLOTS-1:0] valid_reg;
    logic [TASK_SLOTS-1:0] hit;
    logic [TASK_SLOTS-1:0] done_bit;
    logic [PERIOD_W-1:0]   period_reg [TASK_SLOTS];
    logic [TIME_W-1:0]     mark_reg   [TASK_SLOTS];

    for (genvar i = 0; i < TASK_SLOTS; i++)
    begin : g_slot
        logic [TIME_W:0] sum;
        logic            sel;

        // a sum that carries out of 64 bits is never reached
        assign sum    = {1'b0, mark_reg[i]} + {{(TIME_W-PERIOD_W+1){1'b0}}, period_reg[i]};
        assign hit[i] = valid_reg[i] && !sum[TIME_W] && (cmd.now >= sum[TIME_W-1:0]);
        assign sel    = cmd.set && (int'(cmd.index) == i);

        if (i < MASK_W)
        begin : g_rep
            assign done_bit[i] = cmd.done[i];
        end
        else
        begin : g_norep
            assign done_bit[i] = 1'b0;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (cmd.go && sel)
            begin
                valid_reg[i] <= 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (cmd.go && sel)
            begin
                period_reg[i] <= cmd.period;
                mark_reg[i]   <= cmd.now;
            end
            else if (cmd.go && cmd.scan && hit[i] && done_bit[i])
            begin
                // restart the period from now
                mark_reg[i] <= cmd.now;
            end
        end
    end

    for (genvar j = 0; j < MASK_W; j++)
    begin : g_mask
        if (j < TASK_SLOTS)
        begin : g_live
            assign due_mask[j] = hit[j];
        end
        else
        begin : g_dead
            assign due_mask[j] = 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tick_task_scheduler_watchdog.sv
// Tick task scheduler with one-shot delayed event and software watchdog.
// A word passes from the input register to the result register, where it is held until the
// result is taken; throughput one word per cycle while rsp.ready stays high, set by the
// single pass from the input register to the result register. Reset: time, watchdog
// count, timeout flag, delayed event and slot valid bits clear; time_step returns to 1,
// watchdog disabled, bound 0.
`default_nettype none

module tick_task_scheduler_watchdog #(
    parameter int TASK_SLOTS = tts_pkg::TASK_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    tts_in_if.sink                         req,
    tts_out_if.source                      rsp,
    input  logic                           cfg_we,
    input  logic [tts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tts_pkg::*;

    // configuration
    logic [STEP_W-1:0]  step_reg;
    logic               wd_en_reg;
    logic [BOUND_W-1:0] bound_reg;

    // input register
    logic                in_valid_reg;
    logic [OP_W-1:0]     op_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [MASK_W-1:0]   done_reg;
    logic                hok_reg;
    logic [PERIOD_W-1:0] dlen_reg;

    // scheduler state
    logic [TIME_W-1:0]   time_reg,   time_next;
    logic [TIME_W-1:0]   wd_reg,     wd_next;
    logic                flag_reg,   flag_next;
    logic [TIME_W-1:0]   dstart_reg, dstart_next;
    logic [PERIOD_W-1:0] drem_reg,   drem_next;

    // result register
    logic                out_valid_reg;
    logic [MASK_W-1:0]   due_reg;
    logic                fired_reg, fired_next;
    logic                expired_reg, expired_next;
    logic                tseen_reg;
    logic [TIME_W-1:0]   tout_reg;

    logic                advance;
    logic [TIME_W-1:0]   step_ext;
    logic [TIME_W-1:0]   wd_sum;
    logic [TIME_W:0]     delay_sum;
    logic                delay_hit;
    logic [MASK_W-1:0]   due_mask;
    slot_cmd_t           slot_cmd;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= TIME_STEP_RST;
            wd_en_reg <= 1'b0;
            bound_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIME_STEP:       step_reg  <= cfg_data[STEP_W-1:0];
                CFG_WATCHDOG_ENABLE: wd_en_reg <= cfg_data[0];
                CFG_WATCHDOG_BOUND:  bound_reg <= cfg_data[BOUND_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg     <= req.opcode;
            idx_reg    <= req.slot_index;
            period_reg <= req.slot_period;
            done_reg   <= req.done_mask;
            hok_reg    <= req.handler_ok;
            dlen_reg   <= req.delay_length;
        end
    end

    assign step_ext  = {{(TIME_W-STEP_W){1'b0}}, step_reg};
    assign wd_sum    = wd_reg + step_ext;
    assign delay_sum = {1'b0, dstart_reg} + {{(TIME_W-PERIOD_W+1){1'b0}}, drem_reg};
    assign delay_hit = (drem_reg != '0) && !delay_sum[TIME_W]
                       && (time_reg >= delay_sum[TIME_W-1:0]);

    always_comb
    begin
        time_next    = time_reg;
        wd_next      = wd_reg;
        flag_next    = flag_reg;
        dstart_next  = dstart_reg;
        drem_next    = drem_reg;
        fired_next   = 1'b0;
        expired_next = 1'b0;
        case (op_reg)
            OP_TICK:
            begin
                time_next = time_reg + step_ext;
                if (wd_en_reg)
                begin
                    wd_next = wd_sum;
                    if (wd_sum >= {{(TIME_W-BOUND_W){1'b0}}, bound_reg})
                    begin
                        flag_next    = 1'b1;
                        expired_next = 1'b1;
                        if (hok_reg)
                        begin
                            wd_next = '0;
                        end
                    end
                end
            end
            OP_SCAN:
            begin
                if (delay_hit)
                begin
                    // fire once, then disarm
                    fired_next = 1'b1;
                    drem_next  = '0;
                end
            end
            OP_ARM_DELAYED:
            begin
                dstart_next = time_reg;
                drem_next   = dlen_reg;
            end
            OP_KICK:
            begin
                wd_next = '0;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        slot_cmd.go     = advance;
        slot_cmd.scan   = (op_reg == OP_SCAN);
        slot_cmd.set    = (op_reg == OP_SET_TASK);
        slot_cmd.index  = idx_reg;
        slot_cmd.period = period_reg;
        slot_cmd.done   = done_reg;
        slot_cmd.now    = time_reg;
    end

    tts_slots #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_slots (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (slot_cmd),
        .due_mask (due_mask)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg   <= '0;
            wd_reg     <= '0;
            flag_reg   <= 1'b0;
            dstart_reg <= '0;
            drem_reg   <= '0;
        end
        else if (advance)
        begin
            time_reg   <= time_next;
            wd_reg     <= wd_next;
            flag_reg   <= flag_next;
            dstart_reg <= dstart_next;
            drem_reg   <= drem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            due_reg     <= (op_reg == OP_SCAN) ? due_mask : '0;
            fired_reg   <= fired_next;
            expired_reg <= expired_next;
            tseen_reg   <= flag_next;
            tout_reg    <= time_next;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.due_mask         = due_reg;
    assign rsp.delayed_fired    = fired_reg;
    assign rsp.watchdog_expired = expired_reg;
    assign rsp.timeout_seen     = tseen_reg;
    assign rsp.current_time     = tout_reg;

endmodule

`default_nettype wire

FILE: verif/tick_task_scheduler_watchdog_test.sv
// Testbench for the tick task scheduler: random and directed words checked
// against a cycle-free model of time, slot table, delayed event and watchdog.
// Depends on tts_pkg, tts_in_if, tts_out_if and the scheduler RTL.

module tick_task_scheduler_watchdog_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tts_pkg::*;

    localparam int WORDS_PER_PHASE = 60;
    localparam int PHASES          = 8;
    localparam int PRESSURE_PHASE  = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 4000;

    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_KICK + 3'd1;
    localparam logic [OP_W-1:0] OP_LAST_UNUSED  = '1;

    localparam logic [STEP_W-1:0]  PHASE_STEP  [PHASES] = '{1, 1000, 0, 1023, 7, 250, 1, 500};
    localparam logic               PHASE_WD_ON [PHASES] = '{1, 1, 1, 0, 1, 1, 0, 1};
    localparam logic [BOUND_W-1:0] PHASE_BOUND [PHASES] =
        '{0, 32'hFFFF_FFFF, 0, 3000, 20000, 0, 1, 2500};

    typedef struct packed {
        logic [OP_W-1:0]     opcode;
        logic [IDX_W-1:0]    slot_index;
        logic [PERIOD_W-1:0] slot_period;
        logic [MASK_W-1:0]   done_mask;
        logic                handler_ok;
        logic [PERIOD_W-1:0] delay_length;
    } sched_word_t;

    typedef struct packed {
        logic [MASK_W-1:0] due_mask;
        logic              delayed_fired;
        logic              watchdog_expired;
        logic              timeout_seen;
        logic [TIME_W-1:0] current_time;
    } sched_result_t;

    class schedule_tracker;
        logic [STEP_W-1:0]   step;
        logic                wd_on;
        logic [BOUND_W-1:0]  bound;
        logic [TIME_W-1:0]   now_ms;
        logic [TIME_W-1:0]   wd_ms;
        logic                timed_out;
        logic [MASK_W-1:0]   armed;
        logic [PERIOD_W-1:0] periods [TASK_SLOTS_DEF];
        logic [TIME_W-1:0]   marks [TASK_SLOTS_DEF];
        logic [TIME_W-1:0]   delay_from;
        logic [PERIOD_W-1:0] delay_left;
        sched_result_t       pending [$];
        int                  fault_count;

        function new();
            step        = TIME_STEP_RST;
            wd_on       = 1'b0;
            bound       = '0;
            now_ms      = '0;
            wd_ms       = '0;
            timed_out   = 1'b0;
            armed       = '0;
            delay_from  = '0;
            delay_left  = '0;
            fault_count = 0;
            for (int i = 0; i < TASK_SLOTS_DEF; i++)
            begin
                periods[i] = '0;
                marks[i]   = '0;
            end
        endfunction

        // true once now has reached base + span; a sum past 64 bits never does
        static function bit elapsed(logic [TIME_W-1:0] now, logic [TIME_W-1:0] base,
                                    logic [TIME_W-1:0] span);
            logic [TIME_W:0] total;
            total = {1'b0, base} + {1'b0, span};
            return {1'b0, now} >= total;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TIME_STEP:       step  = data[STEP_W-1:0];
                CFG_WATCHDOG_ENABLE: wd_on = data[0];
                CFG_WATCHDOG_BOUND:  bound = data[BOUND_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_word(sched_word_t w);
            sched_result_t r;
            r = '0;
            case (w.opcode)
                OP_TICK:
                begin
                    now_ms = now_ms + step;
                    if (wd_on)
                    begin
                        wd_ms = wd_ms + step;
                        if (wd_ms >= bound)
                        begin
                            timed_out          = 1'b1;
                            r.watchdog_expired = 1'b1;
                            if (w.handler_ok)
                                wd_ms = '0;
                        end
                    end
                end
                OP_SCAN:
                begin
                    for (int i = 0; i < TASK_SLOTS_DEF; i++)
                    begin
                        if (armed[i] && elapsed(now_ms, marks[i], periods[i]))
                        begin
                            r.due_mask[i] = 1'b1;
                            if (w.done_mask[i])
                                marks[i] = now_ms;
                        end
                    end
                    // one-shot: disarm once fired
                    if (delay_left != '0 && elapsed(now_ms, delay_from, delay_left))
                    begin
                        r.delayed_fired = 1'b1;
                        delay_left      = '0;
                    end
                end
                OP_SET_TASK:
                begin
                    if (w.slot_index < TASK_SLOTS_DEF)
                    begin
                        armed[w.slot_index]   = 1'b1;
                        periods[w.slot_index] = w.slot_period;
                        marks[w.slot_index]   = now_ms;
                    end
                end
                OP_ARM_DELAYED:
                begin
                    delay_from = now_ms;
                    delay_left = w.delay_length;
                end
                OP_KICK: wd_ms = '0;
                default: ;
            endcase
            r.timeout_seen = timed_out;
            r.current_time = now_ms;
            pending.push_back(r);
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t want;
            if (pending.size() == 0)
            begin
                $error("result word with nothing outstanding, current_time %0d",
                       got.current_time);
                fault_count++;
                return;
            end
            want = pending.pop_front();
            if (got.due_mask !== want.due_mask)
            begin
                $error("due_mask: expected %h, got %h", want.due_mask, got.due_mask);
                fault_count++;
            end
            if (got.delayed_fired !== want.delayed_fired)
            begin
                $error("delayed_fired: expected %b, got %b",
                       want.delayed_fired, got.delayed_fired);
                fault_count++;
            end
            if (got.watchdog_expired !== want.watchdog_expired)
            begin
                $error("watchdog_expired: expected %b, got %b",
                       want.watchdog_expired, got.watchdog_expired);
                fault_count++;
            end
            if (got.timeout_seen !== want.timeout_seen)
            begin
                $error("timeout_seen: expected %b, got %b",
                       want.timeout_seen, got.timeout_seen);
                fault_count++;
            end
            if (got.current_time !== want.current_time)
            begin
                $error("current_time: expected %0d, got %0d",
                       want.current_time, got.current_time);
                fault_count++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tts_in_if  req_ch ();
    tts_out_if rsp_ch ();

    schedule_tracker tracker;
    int              send_idle_pct;
    int              take_stall_pct;
    int              hold_left;
    int              quiet_cycles;

    tick_task_scheduler_watchdog DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic sched_word_t make_word(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                              logic [PERIOD_W-1:0] period,
                                              logic [MASK_W-1:0] done, logic ok,
                                              logic [PERIOD_W-1:0] delay);
        return {op, idx, period, done, ok, delay};
    endfunction

    // mostly short periods and delays so that slots come due within a phase
    function automatic sched_word_t random_word();
        int          pick;
        sched_word_t w;
        pick = $urandom_range(0, 99);
        if (pick < 34)
            w.opcode = OP_TICK;
        else if (pick < 58)
            w.opcode = OP_SCAN;
        else if (pick < 72)
            w.opcode = OP_SET_TASK;
        else if (pick < 82)
            w.opcode = OP_ARM_DELAYED;
        else if (pick < 92)
            w.opcode = OP_KICK;
        else
            w.opcode = OP_FIRST_UNUSED + OP_W'($urandom_range(0, 2));
        w.slot_index   = IDX_W'($urandom_range(0, 7));
        w.slot_period  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000);
        w.done_mask    = MASK_W'($urandom);
        w.handler_ok   = $urandom_range(0, 1);
        w.delay_length = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4000);
        return w;
    endfunction

    task automatic send_word(input sched_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= w.opcode;
        req_ch.slot_index   <= w.slot_index;
        req_ch.slot_period  <= w.slot_period;
        req_ch.done_mask    <= w.done_mask;
        req_ch.handler_ok   <= w.handler_ok;
        req_ch.delay_length <= w.delay_length;
        do
            @(posedge clk);
        while (!req_ch.ready);
        tracker.note_word(w);
    endtask

    // drop valid and let every outstanding result through the pipeline
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [STEP_W-1:0] step, input logic on,
                                  input logic [BOUND_W-1:0] bound);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TIME_STEP;
        cfg_data  <= CFG_DATA_W'(step);
        @(posedge clk);
        tracker.set_register(CFG_TIME_STEP, CFG_DATA_W'(step));
        cfg_index <= CFG_WATCHDOG_ENABLE;
        cfg_data  <= CFG_DATA_W'(on);
        @(posedge clk);
        tracker.set_register(CFG_WATCHDOG_ENABLE, CFG_DATA_W'(on));
        cfg_index <= CFG_WATCHDOG_BOUND;
        cfg_data  <= CFG_DATA_W'(bound);
        @(posedge clk);
        tracker.set_register(CFG_WATCHDOG_BOUND, CFG_DATA_W'(bound));
        cfg_we <= 1'b0;
    endtask

    // result side: check each accepted word, then choose ready for the next edge
    initial
    begin
        sched_result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                got = {rsp_ch.due_mask, rsp_ch.delayed_fired, rsp_ch.watchdog_expired,
                       rsp_ch.timeout_seen, rsp_ch.current_time};
                tracker.check_result(got);
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= take_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tick_task_scheduler_watchdog: mismatch");
            $finish;
        end
        else
            quiet_cycles++;
    end

    initial
    begin
        logic [BOUND_W-1:0] bound_val;
        clk                 = 1'b0;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.opcode       = OP_TICK;
        req_ch.slot_index   = '0;
        req_ch.slot_period  = '0;
        req_ch.done_mask    = '0;
        req_ch.handler_ok   = 1'b0;
        req_ch.delay_length = '0;
        rsp_ch.ready        = 1'b0;
        send_idle_pct       = 0;
        take_stall_pct      = 0;
        hold_left           = 0;
        quiet_cycles        = 0;
        tracker             = new();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // kick and tick with the watchdog off, then unused opcodes
        send_word(make_word(OP_KICK, 0, 0, 0, 1'b0, 0));
        send_word(make_word(OP_TICK, 0, 0, 0, 1'b1, 0));
        send_word(make_word(OP_FIRST_UNUSED, 0, 0, 0, 1'b0, 0));
        send_word(make_word(OP_LAST_UNUSED, '1, '1, '1, 1'b1, '1));
        // zero period, widest period, short period
        send_word(make_word(OP_SET_TASK, 0, 0, 0, 1'b0, 0));
        send_word(make_word(OP_SET_TASK, 7, 32'hFFFF_FFFF, 0, 1'b0, 0));
        send_word(make_word(OP_SET_TASK, 3, 2, 0, 1'b0, 0));
        send_word(make_word(OP_ARM_DELAYED, 0, 0, 0, 1'b0, 3));
        send_word(make_word(OP_SCAN, 0, 0, '1, 1'b0, 0));
        repeat (3) send_word(make_word(OP_TICK, 0, 0, 0, 1'b0, 0));
        // delayed event fires once only; done bit restarts slot three
        send_word(make_word(OP_SCAN, 0, 0, 8'h00, 1'b0, 0));
        send_word(make_word(OP_SCAN, 0, 0, 8'h08, 1'b0, 0));
        send_word(make_word(OP_ARM_DELAYED, 0, 0, 0, 1'b0, 0));
        send_word(make_word(OP_TICK, 0, 0, 0, 1'b0, 0));
        send_word(make_word(OP_SCAN, 0, 0, '1, 1'b0, 0));
        send_word(make_word(OP_ARM_DELAYED, 0, 0, 0, 1'b0, 32'hFFFF_FFFF));

        // zero bound: every tick expires; kick leaves the sticky flag
        apply_settings(10'd1000, 1'b1, '0);
        send_word(make_word(OP_TICK, 0, 0, 0, 1'b0, 0));
        send_word(make_word(OP_TICK, 0, 0, 0, 1'b1, 0));
        send_word(make_word(OP_KICK, 0, 0, 0, 1'b0, 0));
        send_word(make_word(OP_SCAN, 0, 0, '1, 1'b0, 0));

        // zero step adds nothing to time or watchdog
        apply_settings('0, 1'b1, 32'd5);
        send_word(make_word(OP_TICK, 0, 0, 0, 1'b0, 0));
        send_word(make_word(OP_TICK, 0, 0, 0, 1'b1, 0));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            bound_val = (ph % 3 == 2) ? BOUND_W'($urandom_range(0, 6000)) : PHASE_BOUND[ph];
            apply_settings(PHASE_STEP[ph], PHASE_WD_ON[ph], bound_val);
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    take_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 86;
                    take_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    take_stall_pct = 86;
                end
                default:
                begin
                    send_idle_pct  = 29;
                    take_stall_pct = 29;
                end
            endcase
            // hold the result side off so the pipeline backs up into the input
            if (ph == PRESSURE_PHASE)
                hold_left = HOLD_OFF_CYCLES;
            repeat (WORDS_PER_PHASE) send_word(random_word());
        end

        drain();
        if (tracker.fault_count == 0)
            $display("tick_task_scheduler_watchdog: match");
        else
            $display("tick_task_scheduler_watchdog: mismatch");
        $finish;
    end

endmodule

FILE: files.f
rtl/tts_pkg.sv
rtl/tts_in_if.sv
rtl/tts_out_if.sv
rtl/tts_slots.sv
rtl/tick_task_scheduler_watchdog.sv
verif/tick_task_scheduler_watchdog_test.sv
